@@ hdl/multi_channel_pulse_blink_fade_io_defines.svh @@
// ----------------------------------------------------------------------------
// multi_channel_pulse_blink_fade_io_defines
// Assertion macros shared by the pin engine; the enclosing scope provides clk
// and rst_n.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_PULSE_BLINK_FADE_IO_DEFINES_SVH
`define MULTI_CHANNEL_PULSE_BLINK_FADE_IO_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MCPB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define MCPB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mcpb_pkg.sv @@
// ----------------------------------------------------------------------------
// mcpb_pkg
// Shared types and constants for the multi-channel pulse/blink/fade pin engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpb_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int OUT_W    = (CHANNELS < 16) ? CHANNELS : 16;

  localparam int BLINK_SHIFT = 3;  // blink threshold is 8 times the rate
  localparam int FADE_SHIFT  = 4;
  localparam int HOLD_SHIFT  = 5;
  localparam logic [7:0] FADE_TOP = 8'd255;

  typedef logic [CH_AW-1:0]    ch_addr_t;
  typedef logic [CHANNELS-1:0] ch_vec_t;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SET  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_SET,
    ST_READ
  } seq_state_t;

  typedef struct packed {
    logic        dir_output;
    logic        pull_enable;
    logic [7:0]  period;
    logic [4:0]  blink_rate;
    logic        level;
    logic [7:0]  fade_step;
    logic [15:0] pulse_counter;
    logic [15:0] blink_counter;
    logic [11:0] fade_counter;
    logic        blink_phase;
    logic [7:0]  hold_counter;
  } chan_t;

  localparam chan_t CHAN_RESET = '{
    dir_output:    1'b0,
    pull_enable:   1'b1,
    period:        8'd0,
    blink_rate:    5'd0,
    level:         1'b0,
    fade_step:     8'd0,
    pulse_counter: 16'd0,
    blink_counter: 16'd0,
    fade_counter:  12'd0,
    blink_phase:   1'b0,
    hold_counter:  8'd0
  };

  typedef struct packed {
    logic port;
    logic done;
    logic changed;
  } alu_flags_t;

endpackage

`default_nettype wire

@@ hdl/mcpb_state_mem.sv @@
// ----------------------------------------------------------------------------
// mcpb_state_mem
// Per-channel state memory, one write and one registered read port; entries
// never written read back as the reset state.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpb_state_mem import mcpb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ch_addr_t raddr,
  output chan_t         rdata,
  input  wire logic     we,
  input  wire ch_addr_t waddr,
  input  wire chan_t    wdata
);

  chan_t   mem [CHANNELS];
  chan_t   rdata_r;
  ch_vec_t valid_r;
  logic    rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rvalid_r <= valid_r[raddr];
    end
  end

  assign rdata = rvalid_r ? rdata_r : CHAN_RESET;

endmodule

`default_nettype wire

@@ hdl/mcpb_chan_alu.sv @@
// ----------------------------------------------------------------------------
// mcpb_chan_alu
// Read-modify-write logic for one channel entry: tick update with pin
// sampling, or a set command.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpb_chan_alu import mcpb_pkg::*; (
  input  wire logic       op_set,
  input  wire chan_t      ent_in,
  input  wire logic       port_in,
  input  wire logic [7:0] ticks,
  input  wire logic       pin,
  input  wire logic [7:0] set_byte,
  input  wire logic [7:0] pwm_byte,
  output chan_t           ent_out,
  output alu_flags_t      flags
);

  always_comb begin
    chan_t       e;
    logic        port;
    logic        done;
    logic        chg;
    logic [12:0] limit;
    logic [11:0] fsum;
    logic [7:0]  blink_lim;

    e         = ent_in;
    port      = port_in;
    done      = 1'b0;
    chg       = 1'b0;
    limit     = '0;
    fsum      = '0;
    blink_lim = 8'(e.blink_rate) << BLINK_SHIFT;

    if (op_set) begin
      if (e.dir_output != set_byte[0]) begin
        if (set_byte[0]) begin
          port = 1'b0;
        end else begin
          e.level = 1'b0;
          port    = 1'b1;
        end
        e.dir_output = set_byte[0];
      end
      e.period     = pwm_byte;
      e.blink_rate = set_byte[7:3];
      e.fade_step  = 8'd0;
      if (e.dir_output) begin
        e.level       = set_byte[2];
        e.pull_enable = 1'b0;
        // level with a period starts the fade-in ramp
        if (set_byte[2] && pwm_byte != 8'd0) begin
          e.fade_step = pwm_byte;
          e.period    = FADE_TOP;
          e.level     = 1'b0;
        end
      end else begin
        e.pull_enable = set_byte[1];
        port          = set_byte[1];
      end
    end else if (!e.dir_output) begin
      if (ticks != 8'd0 && e.hold_counter != 8'd0) begin
        e.hold_counter = e.hold_counter + ticks;
      end
      if (e.level != pin) begin
        e.level        = pin;
        e.hold_counter = 8'd1;
        chg            = 1'b1;
      end
      limit = (13'(e.period) << HOLD_SHIFT) | 13'(e.blink_rate);
      if (e.hold_counter != 8'd0 && 13'(e.hold_counter) >= limit) begin
        e.hold_counter = 8'd0;
        done           = 1'b1;
      end
    end else if (ticks != 8'd0) begin
      if (e.period != 8'd0) begin
        e.pulse_counter = e.pulse_counter + 16'(ticks);
      end
      if (e.blink_rate != 5'd0) begin
        e.blink_counter = e.blink_counter + 16'(ticks);
        if (e.blink_counter[15:8] >= blink_lim) begin
          e.blink_counter = 16'd0;
          e.blink_phase   = ~e.blink_phase;
        end
      end
      if (e.level || (e.period != 8'd0 && e.pulse_counter >= 16'(e.period))) begin
        e.pulse_counter = 16'd0;
        port            = (e.blink_rate == 5'd0) || e.blink_phase;
      end else begin
        port = 1'b0;
      end
      if (e.fade_step != 8'd0) begin
        fsum           = e.fade_counter + 12'(ticks);
        e.fade_counter = fsum;
        if (8'(fsum >> FADE_SHIFT) >= e.fade_step) begin
          e.fade_counter  = 12'd0;
          e.period        = e.period - 8'd1;
          e.pulse_counter = 16'd0;
          // ramp finished: settle on a steady high level
          if (e.period == 8'd0) begin
            e.fade_step = 8'd0;
            e.level     = 1'b1;
            chg         = 1'b1;
          end
        end
      end
    end

    ent_out       = e;
    flags.port    = port;
    flags.done    = done;
    flags.changed = chg;
  end

endmodule

`default_nettype wire

@@ hdl/multi_channel_pulse_blink_fade_io.sv @@
// ----------------------------------------------------------------------------
// multi_channel_pulse_blink_fade_io
// Sixteen-channel pin engine: per-channel direction, pull-up, pulse, blink,
// fade-in and input hold detection, with state held in one channel memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command gives
// exactly one result, shown for a single cycle with out_valid; the receiver
// cannot hold it off. A tick walks the channel memory one entry per cycle
// (read, update, write back) and raises the result strobe after the last
// entry. A set or read touches one entry; an out-of-range channel or an unused
// command code touches none and answers straight from idle. out_pin_drive
// always shows the live port bits.
`default_nettype none

`include "multi_channel_pulse_blink_fade_io_defines.svh"

module multi_channel_pulse_blink_fade_io import mcpb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_tick_count,
  input  wire logic [15:0] in_pin_levels,
  input  wire logic [7:0]  in_channel,
  input  wire logic [7:0]  in_set_byte,
  input  wire logic [7:0]  in_pwm_byte,
  output logic             out_valid,
  output logic [15:0]      out_pin_drive,
  output logic [15:0]      out_hold_done,
  output logic             out_data_changed,
  output logic [7:0]       out_status_byte,
  output logic [7:0]       out_period_value,
  output logic             out_read_valid
);

  localparam logic [7:0] CH_LIMIT = 8'(CHANNELS);
  localparam ch_addr_t   CH_LAST  = CH_AW'(CHANNELS - 1);

  seq_state_t state_r, state_nxt;
  ch_addr_t   cnt_r;
  logic [7:0] ticks_r;
  logic [15:0] pins_r;
  logic [7:0] sb_r;
  logic [7:0] pb_r;
  ch_vec_t    port_r;
  ch_vec_t    done_r;
  logic       chg_r;
  logic [7:0] status_r;
  logic [7:0] period_r;
  logic       rvalid_r;
  logic       out_valid_r;

  logic       accept;
  logic       ch_ok;
  logic       last;
  logic       strobe_nxt;
  ch_addr_t   mem_raddr;
  logic       mem_we;
  chan_t      mem_rdata;
  chan_t      alu_ent;
  alu_flags_t alu_flags;
  ch_vec_t    ch_mask;
  ch_vec_t    port_nxt;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign ch_ok  = (in_channel < CH_LIMIT);
  assign last   = (cnt_r == CH_LAST);

  mcpb_state_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (cnt_r),
    .wdata (alu_ent)
  );

  mcpb_chan_alu u_alu (
    .op_set   (state_r == ST_SET),
    .ent_in   (mem_rdata),
    .port_in  (port_r[cnt_r]),
    .ticks    (ticks_r),
    .pin      (1'(pins_r >> cnt_r)),
    .set_byte (sb_r),
    .pwm_byte (pb_r),
    .ent_out  (alu_ent),
    .flags    (alu_flags)
  );

  assign ch_mask  = ch_vec_t'(1) << cnt_r;
  assign port_nxt = alu_flags.port ? (port_r | ch_mask) : (port_r & ~ch_mask);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_TICK: state_nxt = ST_TICK;
            CMD_SET:  state_nxt = ch_ok ? ST_SET : ST_IDLE;
            CMD_READ: state_nxt = ch_ok ? ST_READ : ST_IDLE;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_TICK: state_nxt = last ? ST_IDLE : ST_TICK;
      ST_SET:  state_nxt = ST_IDLE;
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mem_raddr  = cnt_r;
    mem_we     = 1'b0;
    strobe_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        mem_raddr  = (in_cmd == CMD_TICK) ? '0 : in_channel[CH_AW-1:0];
        // commands that touch no entry answer straight away
        strobe_nxt = accept && (state_nxt == ST_IDLE);
      end
      ST_TICK: begin
        mem_we     = 1'b1;
        mem_raddr  = last ? cnt_r : cnt_r + 1'b1;
        strobe_nxt = last;
      end
      ST_SET: begin
        mem_we     = 1'b1;
        strobe_nxt = 1'b1;
      end
      ST_READ: begin
        strobe_nxt = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      port_r      <= '1;
      done_r      <= '0;
      chg_r       <= 1'b0;
      status_r    <= 8'd0;
      period_r    <= 8'd0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= strobe_nxt;
      if (accept) begin
        cnt_r    <= (in_cmd == CMD_TICK) ? '0 : in_channel[CH_AW-1:0];
        done_r   <= '0;
        chg_r    <= 1'b0;
        status_r <= 8'd0;
        period_r <= 8'd0;
        rvalid_r <= 1'b0;
      end
      case (state_r)
        ST_TICK: begin
          port_r <= port_nxt;
          done_r <= alu_flags.done ? (done_r | ch_mask) : done_r;
          chg_r  <= chg_r | alu_flags.changed;
          if (!last) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_SET: begin
          port_r <= port_nxt;
        end
        ST_READ: begin
          status_r <= {mem_rdata.blink_rate, mem_rdata.level,
                       mem_rdata.pull_enable, mem_rdata.dir_output};
          period_r <= mem_rdata.period;
          rvalid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload of the accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      ticks_r <= in_tick_count;
      pins_r  <= in_pin_levels;
      sb_r    <= in_set_byte;
      pb_r    <= in_pwm_byte;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pin_drive    = 16'(port_r[OUT_W-1:0]);
  assign out_hold_done    = 16'(done_r[OUT_W-1:0]);
  assign out_data_changed = chg_r;
  assign out_status_byte  = status_r;
  assign out_period_value = period_r;
  assign out_read_valid   = rvalid_r;

  `MCPB_ASSERT_IMP(a_strobe_idle, out_valid_r, state_r == ST_IDLE, "result strobe while busy")
  `MCPB_ASSERT_NXT(a_walk_step, (state_r == ST_TICK) && !last, (state_r == ST_TICK) && (cnt_r == CH_AW'($past(cnt_r) + 1'b1)), "tick walk skipped an entry")
  `MCPB_ASSERT_IMP(a_read_clean, out_valid_r && rvalid_r, (done_r == '0) && !chg_r, "read result carries tick flags")

endmodule

`default_nettype wire

@@ bench/tb_multi_channel_pulse_blink_fade_io.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_channel_pulse_blink_fade_io
// Self-checking bench for the sixteen-channel pin engine. A short table of
// commands covers reset values, field extremes and the odd cases, then a
// long random run with armed fade-ins and slowly moving pin levels follows.
// Every response is compared field by field against a typed row or the in-bench model.
// ----------------------------------------------------------------------------
module tb_multi_channel_pulse_blink_fade_io;
  import mcpb_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 800;
  localparam int CALM_FROM     = 300;
  localparam int CALM_TO       = 460;
  localparam int DRAIN_CYCLES  = 24;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  ticks;
    logic [15:0] pins;
    logic [7:0]  chan;
    logic [7:0]  set_byte;
    logic [7:0]  pwm;
  } cmd_item_t;

  typedef struct packed {
    logic [15:0] pin_drive;
    logic [15:0] hold_done;
    logic        data_changed;
    logic [7:0]  status_byte;
    logic [7:0]  period_value;
    logic        read_valid;
  } report_t;

  typedef struct {
    cmd_item_t item;
    bit        known;
    report_t   typed;
  } directed_row_t;

  localparam report_t NO_TYPED = '0;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_cmd;
  logic [7:0]  in_tick_count;
  logic [15:0] in_pin_levels;
  logic [7:0]  in_channel;
  logic [7:0]  in_set_byte;
  logic [7:0]  in_pwm_byte;
  logic        out_valid;
  logic [15:0] out_pin_drive;
  logic [15:0] out_hold_done;
  logic        out_data_changed;
  logic [7:0]  out_status_byte;
  logic [7:0]  out_period_value;
  logic        out_read_valid;

  multi_channel_pulse_blink_fade_io uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_tick_count    (in_tick_count),
    .in_pin_levels    (in_pin_levels),
    .in_channel       (in_channel),
    .in_set_byte      (in_set_byte),
    .in_pwm_byte      (in_pwm_byte),
    .out_valid        (out_valid),
    .out_pin_drive    (out_pin_drive),
    .out_hold_done    (out_hold_done),
    .out_data_changed (out_data_changed),
    .out_status_byte  (out_status_byte),
    .out_period_value (out_period_value),
    .out_read_valid   (out_read_valid)
  );

  // engine image kept by the bench
  chan_t       chan_state [CHANNELS];
  logic [15:0] port_bits;
  logic [15:0] pins_now;

  report_t engine_reports_due [$];
  report_t due_report;
  int      mismatch_count;
  int      cycle_count;

  directed_row_t directed_table [DIRECTED_ROWS] = '{
    '{'{CMD_READ, 8'd0, 16'h0000, 8'd0, 8'h00, 8'h00}, 1'b1,
      '{16'hFFFF, 16'h0000, 1'b0, 8'h02, 8'h00, 1'b1}},
    '{'{CMD_READ, 8'd0, 16'h0000, 8'd255, 8'h00, 8'h00}, 1'b1,
      '{16'hFFFF, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_TICK, 8'd0, 16'h0000, 8'd0, 8'h00, 8'h00}, 1'b1,
      '{16'hFFFF, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_UNUSED, 8'd255, 16'hFFFF, 8'd0, 8'hFF, 8'hFF}, 1'b1,
      '{16'hFFFF, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_SET, 8'd0, 16'h0000, 8'd16, 8'hFF, 8'hFF}, 1'b1,
      '{16'hFFFF, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_SET, 8'd0, 16'h0000, 8'd0, 8'h05, 8'h00}, 1'b1,
      '{16'hFFFE, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_TICK, 8'd1, 16'h0000, 8'd0, 8'h00, 8'h00}, 1'b0, NO_TYPED},
    '{'{CMD_SET, 8'd0, 16'h0000, 8'd1, 8'h05, 8'h01}, 1'b0, NO_TYPED},
    '{'{CMD_READ, 8'd0, 16'h0000, 8'd1, 8'h00, 8'h00}, 1'b0, NO_TYPED},
    '{'{CMD_TICK, 8'd255, 16'hFFFF, 8'd0, 8'h00, 8'h00}, 1'b0, NO_TYPED},
    '{'{CMD_SET, 8'd0, 16'h0000, 8'd2, 8'hF8, 8'h07}, 1'b0, NO_TYPED},
    '{'{CMD_TICK, 8'd0, 16'h0000, 8'd0, 8'h00, 8'h00}, 1'b0, NO_TYPED},
    '{'{CMD_TICK, 8'd255, 16'h0000, 8'd0, 8'h00, 8'h00}, 1'b0, NO_TYPED},
    '{'{CMD_SET, 8'd0, 16'h0000, 8'd3, 8'h09, 8'hFF}, 1'b0, NO_TYPED},
    '{'{CMD_SET, 8'd0, 16'h0000, 8'd5, 8'hFF, 8'hFF}, 1'b0, NO_TYPED},
    '{'{CMD_TICK, 8'd255, 16'h5555, 8'd0, 8'h00, 8'h00}, 1'b0, NO_TYPED},
    '{'{CMD_SET, 8'd0, 16'h0000, 8'd4, 8'hFD, 8'h00}, 1'b0, NO_TYPED},
    '{'{CMD_TICK, 8'd255, 16'hAAAA, 8'd0, 8'h00, 8'h00}, 1'b0, NO_TYPED},
    '{'{CMD_SET, 8'd0, 16'h0000, 8'd0, 8'h02, 8'h00}, 1'b0, NO_TYPED},
    '{'{CMD_READ, 8'd0, 16'h0000, 8'd5, 8'h00, 8'h00}, 1'b0, NO_TYPED},
    '{'{CMD_READ, 8'd0, 16'h0000, 8'd2, 8'h00, 8'h00}, 1'b0, NO_TYPED},
    '{'{CMD_SET, 8'd0, 16'h0000, 8'd6, 8'h00, 8'h00}, 1'b0, NO_TYPED},
    '{'{CMD_TICK, 8'd128, 16'hFFFF, 8'd0, 8'h00, 8'h00}, 1'b0, NO_TYPED},
    '{'{CMD_READ, 8'd0, 16'h0000, 8'd15, 8'h00, 8'h00}, 1'b0, NO_TYPED},
    '{'{CMD_SET, 8'd0, 16'h0000, 8'd255, 8'h07, 8'h10}, 1'b0, NO_TYPED}
  };

  function automatic void reset_pin_engine();
    foreach (chan_state[i]) chan_state[i] = CHAN_RESET;
    port_bits = '1;
  endfunction

  // advances the engine image by one command and returns its response
  function automatic report_t advance_pin_engine(cmd_item_t it);
    report_t     r;
    chan_t       c;
    logic [15:0] done;
    logic        changed;
    int          chn;
    int          limit;
    r = '0;
    done = '0;
    changed = 1'b0;
    chn = int'(it.chan);
    case (it.cmd)
      CMD_TICK: begin
        if (it.ticks != 8'd0) begin
          for (int i = 0; i < CHANNELS; i++) begin
            c = chan_state[i];
            if (!c.dir_output) begin
              if (c.hold_counter != 8'd0) c.hold_counter = c.hold_counter + it.ticks;
            end else begin
              if (c.period != 8'd0) c.pulse_counter = c.pulse_counter + it.ticks;
              if (c.blink_rate != 5'd0) begin
                c.blink_counter = c.blink_counter + it.ticks;
                if (int'(c.blink_counter >> 8) >= (int'(c.blink_rate) << BLINK_SHIFT)) begin
                  c.blink_counter = '0;
                  c.blink_phase = ~c.blink_phase;
                end
              end
              if (c.level || (c.period != 8'd0 && c.pulse_counter >= 16'(c.period))) begin
                c.pulse_counter = '0;
                port_bits[i] = (c.blink_rate == 5'd0) || c.blink_phase;
              end else begin
                port_bits[i] = 1'b0;
              end
              if (c.fade_step != 8'd0) begin
                c.fade_counter = c.fade_counter + it.ticks;
                if (int'(c.fade_counter >> FADE_SHIFT) >= int'(c.fade_step)) begin
                  c.fade_counter = '0;
                  c.period = c.period - 8'd1;
                  c.pulse_counter = '0;
                  // ramp finished: steady high from here on
                  if (c.period == 8'd0) begin
                    c.fade_step = '0;
                    c.level = 1'b1;
                    changed = 1'b1;
                  end
                end
              end
            end
            chan_state[i] = c;
          end
        end
        for (int i = 0; i < CHANNELS; i++) begin
          c = chan_state[i];
          if (!c.dir_output) begin
            if (c.level != it.pins[i]) begin
              c.level = it.pins[i];
              c.hold_counter = 8'd1;
              changed = 1'b1;
            end
            limit = (int'(c.period) << HOLD_SHIFT) | int'(c.blink_rate);
            if (c.hold_counter != 8'd0 && int'(c.hold_counter) >= limit) begin
              c.hold_counter = '0;
              done[i] = 1'b1;
            end
          end
          chan_state[i] = c;
        end
      end
      CMD_SET: begin
        if (chn < CHANNELS) begin
          c = chan_state[chn];
          if (c.dir_output != it.set_byte[0]) begin
            if (it.set_byte[0]) begin
              port_bits[chn] = 1'b0;
            end else begin
              c.period = '0;
              c.blink_rate = '0;
              c.level = 1'b0;
              port_bits[chn] = 1'b1;
            end
            c.dir_output = it.set_byte[0];
          end
          c.period = it.pwm;
          c.blink_rate = it.set_byte[7:3];
          c.fade_step = '0;
          if (c.dir_output) begin
            c.level = it.set_byte[2];
            c.pull_enable = 1'b0;
            if (c.level && c.period != 8'd0) begin
              c.fade_step = c.period;
              c.period = FADE_TOP;
              c.level = 1'b0;
            end
          end else begin
            c.pull_enable = it.set_byte[1];
            port_bits[chn] = c.pull_enable;
          end
          chan_state[chn] = c;
        end
      end
      CMD_READ: begin
        if (chn < CHANNELS) begin
          c = chan_state[chn];
          r.status_byte = {c.blink_rate, c.level, c.pull_enable, c.dir_output};
          r.period_value = c.period;
          r.read_valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.pin_drive = port_bits;
    r.hold_done = done;
    r.data_changed = changed;
    return r;
  endfunction

  // output on, level set, nonzero period: starts a fade-in from the top
  function automatic cmd_item_t arm_fade(logic [7:0] chn, logic [7:0] step);
    cmd_item_t it;
    it = '0;
    it.cmd = CMD_SET;
    it.pins = pins_now;
    it.chan = chn;
    it.set_byte = {5'($urandom_range(0, 2)), 3'b101};
    it.pwm = step;
    return it;
  endfunction

  function automatic cmd_item_t random_command();
    cmd_item_t it;
    int        roll;
    roll = $urandom_range(0, 99);
    it.cmd = CMD_TICK;
    it.ticks = 8'($urandom);
    it.pins = 16'($urandom);
    it.chan = 8'($urandom);
    it.set_byte = 8'($urandom);
    it.pwm = 8'($urandom);
    if (roll < 70) begin
      case ($urandom_range(0, 19))
        0:       it.ticks = 8'd0;
        1, 2:    it.ticks = 8'($urandom_range(1, 15));
        default: it.ticks = 8'($urandom_range(16, 255));
      endcase
      // pins mostly steady so that holds get time to run out
      case ($urandom_range(0, 9))
        6, 7, 8: pins_now = pins_now ^ (16'h0001 << $urandom_range(0, 15));
        9:       pins_now = 16'($urandom);
        default: ;
      endcase
      it.pins = pins_now;
    end else if (roll < 90) begin
      it.cmd = CMD_SET;
      // channels 14 and 15 are left to their fade-ins here
      if ($urandom_range(0, 99) < 8) it.chan = 8'($urandom_range(16, 255));
      else it.chan = 8'($urandom_range(0, 13));
      if ($urandom_range(0, 1) == 1) it.set_byte[7:3] = 5'($urandom_range(0, 1));
      if ($urandom_range(0, 1) == 1) it.pwm = 8'($urandom_range(0, 7));
    end else if (roll < 98) begin
      it.cmd = CMD_READ;
      if ($urandom_range(0, 9) == 0) it.chan = 8'($urandom_range(16, 255));
      else it.chan = 8'($urandom_range(0, 15));
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task automatic send_command(cmd_item_t it, bit known, report_t typed);
    report_t predicted;
    @(negedge clk);
    start = 1'b1;
    in_cmd = it.cmd;
    in_tick_count = it.ticks;
    in_pin_levels = it.pins;
    in_channel = it.chan;
    in_set_byte = it.set_byte;
    in_pwm_byte = it.pwm;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = advance_pin_engine(it);
    engine_reports_due.push_back(known ? typed : predicted);
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (engine_reports_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: response transaction with nothing outstanding", $realtime);
      end else begin
        due_report = engine_reports_due.pop_front();
        check_field("pin_drive", due_report.pin_drive, out_pin_drive);
        check_field("hold_done", due_report.hold_done, out_hold_done);
        check_field("data_changed", 16'(due_report.data_changed), 16'(out_data_changed));
        check_field("status_byte", 16'(due_report.status_byte), 16'(out_status_byte));
        check_field("period_value", 16'(due_report.period_value), 16'(out_period_value));
        check_field("read_valid", 16'(due_report.read_valid), 16'(out_read_valid));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_TICK;
    in_tick_count = '0;
    in_pin_levels = '0;
    in_channel = '0;
    in_set_byte = '0;
    in_pwm_byte = '0;
    mismatch_count = 0;
    pins_now = '0;
    reset_pin_engine();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_table[r]) begin
      send_command(directed_table[r].item, directed_table[r].known, directed_table[r].typed);
      if ($urandom_range(0, 99) < 22) idle_for($urandom_range(1, 20));
    end
    pins_now = 16'hFFFF;

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // a step of one lets a full ramp finish within the run
      if (k == 0) send_command(arm_fade(8'd15, 8'd1), 1'b0, NO_TYPED);
      if (k % 400 == 0)
        send_command(arm_fade(8'd14, 8'($urandom_range(1, 2))), 1'b0, NO_TYPED);
      send_command(random_command(), 1'b0, NO_TYPED);
      if ((k < CALM_FROM || k >= CALM_TO) && $urandom_range(0, 99) < 22)
        idle_for($urandom_range(1, 20));
    end
    idle_for(1);

    while (engine_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
